>>> sv/bspce_pkg.sv
// Shared types and constants for the B-spline curve point evaluator.
`default_nettype none

package bspce_pkg;

  typedef logic [1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_LAST_POINT_INDEX = 2'd0;
  localparam cfg_idx_t CFG_CURVE_ORDER      = 2'd1;
  localparam cfg_idx_t CFG_NUM_SAMPLES      = 2'd2;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EVAL = 1'b1;

  localparam logic [5:0]  LAST_POINT_INDEX_RST = 6'd3;
  localparam logic [2:0]  CURVE_ORDER_RST      = 3'd4;
  localparam logic [15:0] NUM_SAMPLES_RST      = 16'd1000;

  localparam logic [16:0] BASIS_ONE = 17'h10000;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PREP,
    ST_FIN_RD,
    ST_FIN_WAIT,
    ST_VMUL,
    ST_VDIV_GO,
    ST_VDIV_WAIT,
    ST_INIT,
    ST_PASS_RD,
    ST_PASS_WAIT,
    ST_NEXT_RD,
    ST_NEXT_WAIT,
    ST_L_MUL,
    ST_L_DIV_GO,
    ST_L_DIV_WAIT,
    ST_R_MUL,
    ST_R_DIV_GO,
    ST_R_DIV_WAIT,
    ST_WRITE,
    ST_SUM_RD,
    ST_SUM_WAIT,
    ST_SUM_X,
    ST_SUM_Y,
    ST_SUM_Z,
    ST_SUM_ACC,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

>>> sv/bspline_curve_point_evaluator.sv
// Top level: open uniform B-spline curve point evaluator, Cox-de Boor in fixed point.
// Load transaction: written to the point store in the accept cycle.
// Evaluate: (t-1) basis update passes of n+t+1-r entries each, using the shared multiplier
//   and the bit-serial divider, then a sum over the n+1 control points. Not ready meanwhile.
// Reset: synchronous active-low rst_n clears control state and restores registers.
`default_nettype none

module bspline_curve_point_evaluator
  import bspce_pkg::*;
#(
  parameter int MAX_POINTS = 64,
  parameter int MAX_ORDER  = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // point_index[5:0], point_x[21:6], point_y[37:22], point_z[53:38], sample_index[69:54]
  input  wire logic [71:0] in_tdata,
  // action[0]
  input  wire logic        in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // curve_x[23:0], curve_y[47:24], curve_z[71:48], sample_echo[87:72]
  output logic [87:0]      out_tdata,
  // no_curve[0]
  output logic             out_tuser,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire cfg_idx_t    cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int AW  = $clog2(MAX_POINTS);
  localparam int BD  = MAX_POINTS + MAX_ORDER;
  localparam int JW  = $clog2(MAX_POINTS + MAX_ORDER + 1);
  localparam int TW  = $clog2(MAX_ORDER + 1);
  localparam int VW  = AW + 16;
  localparam int MA  = AW + 18;
  localparam int MB  = 18;
  localparam int PW  = MA + MB;
  localparam int NW  = AW + 32;
  localparam int ACW = AW + 35;
  localparam logic signed [ACW-1:0] QMAX = ACW'(8388607);
  localparam logic signed [ACW-1:0] QMIN = -ACW'(8388608);

  state_t state_r, state_nxt;

  logic [5:0]  lpi_r;
  logic [2:0]  order_r;
  logic [15:0] ns_r;

  logic [47:0] pt_mem [MAX_POINTS];
  logic [16:0] bs_mem [BD];
  logic [47:0] pt_rdata_r;
  logic [16:0] bs_rdata_r;

  logic          pt_ren;
  logic [AW-1:0] pt_raddr;
  logic          bs_ren;
  logic [JW-1:0] bs_raddr;
  logic          bs_we;
  logic [JW-1:0] bs_waddr;
  logic [16:0]   bs_wdata;

  logic signed [MA-1:0] mul_a;
  logic signed [MB-1:0] mul_b;
  logic signed [PW-1:0] mul_p;
  logic                 div_start;
  logic [NW-1:0]        div_num;
  logic [15:0]          div_den;
  logic                 div_done;
  logic [NW-1:0]        div_q;

  logic [15:0]   s_r;
  logic [VW-1:0] v_r;
  logic [JW-1:0] j_r;
  logic [TW-1:0] r_r;
  logic [AW-1:0] k_r;
  logic [16:0]   cur_r;
  logic [16:0]   nxt_r;
  logic [16:0]   lterm_r;
  logic [16:0]   rterm_r;
  logic          nocurve_r;
  logic          fin_r;
  logic signed [ACW-1:0] acc_x_r, acc_y_r, acc_z_r;
  logic          out_valid_r;
  logic [87:0]   out_data_r;
  logic          out_user_r;

  logic          in_acc;
  logic [AW-1:0] n_w;
  logic [TW-1:0] t_w;
  logic [AW-1:0] span_w;
  logic          nocurve_w;
  logic          final_w;
  logic [JW-1:0] init_last;
  logic [JW-1:0] pass_last;
  logic [JW-1:0] j1;
  logic [JW-1:0] jr;
  logic [JW-1:0] jr1;
  logic [AW-1:0] kj, kj1, kjr, kjr1, vi;
  logic signed [MA-1:0] a_l, a_r;
  logic signed [AW:0]   d_l, d_r;
  logic          triv_l, triv_r;
  logic          out_go;

  function automatic logic [AW-1:0] knot_at(input logic [JW-1:0] j, input logic [AW-1:0] n,
                                            input logic [TW-1:0] t, input logic [AW-1:0] sp);
    logic [JW-1:0] jt;
    jt = JW'(t);
    if (j < jt) knot_at = '0;
    else if (j <= JW'(n)) knot_at = AW'(j - jt + JW'(1));
    else knot_at = sp;
  endfunction

  function automatic logic [23:0] to_q168(input logic signed [ACW-1:0] q);
    logic signed [ACW-1:0] r;
    r = q >>> 8;
    if (r > QMAX) r = QMAX;
    if (r < QMIN) r = QMIN;
    to_q168 = r[23:0];
  endfunction

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_go     = !out_valid_r || out_tready;

  always_comb begin
    n_w = (32'(lpi_r) > 32'(MAX_POINTS - 1)) ? AW'(MAX_POINTS - 1) : AW'(lpi_r);
    if (32'(order_r) < 32'd2) t_w = TW'(2);
    else if (32'(order_r) > 32'(MAX_ORDER)) t_w = TW'(MAX_ORDER);
    else t_w = TW'(order_r);
    nocurve_w = (32'(n_w) + 32'd2) <= 32'(t_w);
    span_w    = AW'(32'(n_w) - 32'(t_w) + 32'd2);
    final_w   = (ns_r < 16'd2) || (s_r >= ns_r - 16'd1);
    init_last = JW'(n_w) + JW'(t_w) - JW'(1);
    pass_last = JW'(n_w) + JW'(t_w) - JW'(r_r);
    j1        = j_r + JW'(1);
    jr        = j_r + JW'(r_r);
    jr1       = jr - JW'(1);
    kj        = knot_at(j_r, n_w, t_w, span_w);
    kj1       = knot_at(j1, n_w, t_w, span_w);
    kjr       = knot_at(jr, n_w, t_w, span_w);
    kjr1      = knot_at(jr1, n_w, t_w, span_w);
    vi        = v_r[VW-1:16];
    a_l       = $signed({2'b00, v_r}) - $signed({2'b00, kj, 16'h0000});
    a_r       = $signed({2'b00, kjr, 16'h0000}) - $signed({2'b00, v_r});
    d_l       = $signed({1'b0, kjr1}) - $signed({1'b0, kj});
    d_r       = $signed({1'b0, kjr}) - $signed({1'b0, kj1});
    triv_l    = (d_l <= 0) || (a_l <= 0) || (cur_r == '0);
    triv_r    = (d_r <= 0) || (a_r <= 0) || (nxt_r == '0);
  end

  bspce_mul #(.AW(MA), .BW(MB)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  bspce_div #(.NW(NW), .DW(16)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (div_num),
    .den    (div_den),
    .done_r (div_done),
    .quo_r  (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lpi_r   <= LAST_POINT_INDEX_RST;
      order_r <= CURVE_ORDER_RST;
      ns_r    <= NUM_SAMPLES_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LAST_POINT_INDEX: lpi_r   <= cfg_data[5:0];
        CFG_CURVE_ORDER:      order_r <= cfg_data[2:0];
        CFG_NUM_SAMPLES:      ns_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_tuser == ACT_LOAD) && (32'(in_tdata[5:0]) < 32'(MAX_POINTS))) begin
      pt_mem[AW'(in_tdata[5:0])] <= in_tdata[53:6];
    end
    if (pt_ren) begin
      pt_rdata_r <= pt_mem[pt_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (bs_we) begin
      bs_mem[bs_waddr] <= bs_wdata;
    end
    if (bs_ren) begin
      bs_rdata_r <= bs_mem[bs_raddr];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:       if (in_acc && (in_tuser == ACT_EVAL)) state_nxt = ST_PREP;
      ST_PREP: begin
        if (nocurve_w) state_nxt = ST_OUT;
        else if (final_w) state_nxt = ST_FIN_RD;
        else state_nxt = ST_VMUL;
      end
      ST_FIN_RD:     state_nxt = ST_FIN_WAIT;
      ST_FIN_WAIT:   state_nxt = ST_OUT;
      ST_VMUL:       state_nxt = ST_VDIV_GO;
      ST_VDIV_GO:    state_nxt = ST_VDIV_WAIT;
      ST_VDIV_WAIT:  if (div_done) state_nxt = ST_INIT;
      ST_INIT:       if (j_r == init_last) state_nxt = ST_PASS_RD;
      ST_PASS_RD:    state_nxt = ST_PASS_WAIT;
      ST_PASS_WAIT:  state_nxt = ST_NEXT_RD;
      ST_NEXT_RD:    state_nxt = ST_NEXT_WAIT;
      ST_NEXT_WAIT:  state_nxt = ST_L_MUL;
      ST_L_MUL:      state_nxt = triv_l ? ST_R_MUL : ST_L_DIV_GO;
      ST_L_DIV_GO:   state_nxt = ST_L_DIV_WAIT;
      ST_L_DIV_WAIT: if (div_done) state_nxt = ST_R_MUL;
      ST_R_MUL:      state_nxt = triv_r ? ST_WRITE : ST_R_DIV_GO;
      ST_R_DIV_GO:   state_nxt = ST_R_DIV_WAIT;
      ST_R_DIV_WAIT: if (div_done) state_nxt = ST_WRITE;
      ST_WRITE: begin
        if (j_r != pass_last) state_nxt = ST_NEXT_RD;
        else if (r_r == t_w) state_nxt = ST_SUM_RD;
        else state_nxt = ST_PASS_RD;
      end
      ST_SUM_RD:     state_nxt = ST_SUM_WAIT;
      ST_SUM_WAIT:   state_nxt = ST_SUM_X;
      ST_SUM_X:      state_nxt = ST_SUM_Y;
      ST_SUM_Y:      state_nxt = ST_SUM_Z;
      ST_SUM_Z:      state_nxt = ST_SUM_ACC;
      ST_SUM_ACC:    state_nxt = (k_r == n_w) ? ST_OUT : ST_SUM_RD;
      ST_OUT:        if (out_go) state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    pt_ren    = 1'b0;
    pt_raddr  = k_r;
    bs_ren    = 1'b0;
    bs_raddr  = JW'(k_r);
    bs_we     = 1'b0;
    bs_waddr  = j_r;
    bs_wdata  = lterm_r + rterm_r;
    mul_a     = a_l;
    mul_b     = $signed({1'b0, cur_r});
    div_start = 1'b0;
    div_num   = NW'(mul_p[PW-1:16]);
    div_den   = 16'(d_l[AW-1:0]);
    unique case (state_r)
      ST_FIN_RD: begin
        pt_ren   = 1'b1;
        pt_raddr = n_w;
      end
      ST_VMUL: begin
        mul_a = $signed(MA'(s_r));
        mul_b = $signed(MB'(span_w));
      end
      ST_VDIV_GO: begin
        div_start = 1'b1;
        div_num   = NW'({mul_p[16+AW-1:0], 16'h0000});
        div_den   = ns_r - 16'd1;
      end
      ST_INIT: begin
        bs_we    = 1'b1;
        bs_wdata = ((kj <= vi) && (vi < kj1)) ? BASIS_ONE : '0;
      end
      ST_PASS_RD: begin
        bs_ren   = 1'b1;
        bs_raddr = '0;
      end
      ST_NEXT_RD: begin
        bs_ren   = 1'b1;
        bs_raddr = j1;
      end
      ST_L_DIV_GO: div_start = 1'b1;
      ST_R_MUL: begin
        mul_a = a_r;
        mul_b = $signed({1'b0, nxt_r});
      end
      ST_R_DIV_GO: begin
        div_start = 1'b1;
        div_den   = 16'(d_r[AW-1:0]);
      end
      ST_WRITE: bs_we = 1'b1;
      ST_SUM_RD: begin
        pt_ren = 1'b1;
        bs_ren = 1'b1;
      end
      ST_SUM_X: begin
        mul_a = MA'($signed(pt_rdata_r[15:0]));
        mul_b = $signed({1'b0, bs_rdata_r});
      end
      ST_SUM_Y: begin
        mul_a = MA'($signed(pt_rdata_r[31:16]));
        mul_b = $signed({1'b0, bs_rdata_r});
      end
      ST_SUM_Z: begin
        mul_a = MA'($signed(pt_rdata_r[47:32]));
        mul_b = $signed({1'b0, bs_rdata_r});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == ST_OUT) && out_go) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: if (in_acc) s_r <= in_tdata[69:54];
      ST_PREP: begin
        nocurve_r <= nocurve_w;
        fin_r     <= final_w;
        acc_x_r   <= '0;
        acc_y_r   <= '0;
        acc_z_r   <= '0;
      end
      ST_VDIV_WAIT: begin
        v_r <= div_q[VW-1:0];
        j_r <= '0;
      end
      ST_INIT: begin
        if (j_r == init_last) begin
          j_r <= '0;
          r_r <= TW'(2);
        end else begin
          j_r <= j1;
        end
      end
      ST_PASS_WAIT: cur_r <= bs_rdata_r;
      ST_NEXT_WAIT: nxt_r <= bs_rdata_r;
      ST_L_MUL: if (triv_l) lterm_r <= '0;
      ST_L_DIV_WAIT: if (div_done) lterm_r <= div_q[16:0];
      ST_R_MUL: if (triv_r) rterm_r <= '0;
      ST_R_DIV_WAIT: if (div_done) rterm_r <= div_q[16:0];
      ST_WRITE: begin
        cur_r <= nxt_r;
        if (j_r != pass_last) begin
          j_r <= j1;
        end else begin
          j_r <= '0;
          k_r <= '0;
          r_r <= r_r + TW'(1);
        end
      end
      ST_SUM_Y: acc_x_r <= acc_x_r + ACW'($signed(mul_p[33:0]));
      ST_SUM_Z: acc_y_r <= acc_y_r + ACW'($signed(mul_p[33:0]));
      ST_SUM_ACC: begin
        acc_z_r <= acc_z_r + ACW'($signed(mul_p[33:0]));
        k_r     <= k_r + AW'(1);
      end
      ST_OUT: begin
        if (out_go) begin
          out_user_r <= nocurve_r;
          if (nocurve_r) begin
            out_data_r <= {s_r, 72'h0};
          end else if (fin_r) begin
            out_data_r <= {s_r, pt_rdata_r[47:32], 8'h00, pt_rdata_r[31:16], 8'h00,
                           pt_rdata_r[15:0], 8'h00};
          end else begin
            out_data_r <= {s_r, to_q168(acc_z_r), to_q168(acc_y_r), to_q168(acc_x_r)};
          end
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> sv/bspce_mul.sv
// Shared signed multiplier with registered product.
`default_nettype none

module bspce_mul #(
  parameter int AW = 20,
  parameter int BW = 18
) (
  input  wire logic                     clk,
  input  wire logic signed [AW-1:0]     a,
  input  wire logic signed [BW-1:0]     b,
  output logic signed [AW+BW-1:0]       p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

`default_nettype wire

>>> sv/bspce_div.sv
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none

module bspce_div #(
  parameter int NW = 38,
  parameter int DW = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done_r,
  output logic [NW-1:0]      quo_r
);

  localparam int CW = $clog2(NW + 1);

  logic [DW:0]   rem_r;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic          run_r;
  logic [DW:0]   rem_sh;
  logic          qbit;
  logic [DW:0]   rem_nxt;

  always_comb begin
    rem_sh  = {rem_r[DW-1:0], quo_r[NW-1]};
    qbit    = (rem_sh >= {1'b0, den_r});
    rem_nxt = qbit ? (rem_sh - {1'b0, den_r}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CW'(NW);
      end else if (run_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (run_r) begin
      quo_r <= {quo_r[NW-2:0], qbit};
      rem_r <= rem_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/bspce_checker.sv
// Port-level checker for the B-spline curve point evaluator and its bind.
`default_nettype none

module bspce_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [87:0] out_tdata,
  input wire logic        out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped before transaction");

  a_nocurve_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> (out_tdata[71:0] == 72'h0))
    else $error("no-curve result carries nonzero point");

  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> !in_tready)
    else $error("evaluate transaction did not block input");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("reset did not clear result channel");

endmodule

bind bspline_curve_point_evaluator bspce_checker u_bspce_checker (.*);

`default_nettype wire
